### rtl/apsp_pkg.sv
// Shared types, constants and memory request structures for the shortest path engine.
`default_nettype none

package apsp_pkg;

  localparam int MAX_NODES   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int ADDR_W      = 2 * NODE_W;
  localparam int NUM_ENTRIES = MAX_NODES * MAX_NODES;
  localparam int FUNC_W      = 2;
  localparam int WEIGHT_W    = 16;
  localparam int DIST_W      = 20;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_RELAX,
    ST_WALK_START,
    ST_WALK_HOP,
    ST_WALK_DIST,
    ST_EMIT
  } state_e;

  // A distance with its infinity mark on top, so that a plain compare orders it.
  typedef struct packed {
    logic              inf;
    logic [DIST_W-1:0] val;
  } dist_t;

  typedef struct packed {
    logic  none;
    node_t node;
  } hop_t;

  typedef struct packed {
    dist_t cost;
    hop_t  hop;
  } path_entry_t;

  typedef struct packed {
    logic                no_arc;
    logic [WEIGHT_W-1:0] weight;
  } arc_entry_t;

  typedef struct packed {
    logic                clr;
    logic                wr_en;
    addr_t               wr_addr;
    logic [WEIGHT_W-1:0] wr_weight;
    addr_t               rd_addr;
  } arc_req_t;

  typedef struct packed {
    logic        wr_en;
    addr_t       wr_addr;
    path_entry_t wr_data;
    addr_t       rd_a_addr;
    addr_t       rd_b_addr;
  } path_req_t;

endpackage

`default_nettype wire

### rtl/apsp_arc_mem.sv
// Adjacency matrix memory with per-entry valid bits standing in for the reset contents.
`default_nettype none

module apsp_arc_mem (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  apsp_pkg::arc_req_t   req_i,
  output apsp_pkg::arc_entry_t rd_o
);
  import apsp_pkg::*;

  logic [WEIGHT_W-1:0]    mem [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [WEIGHT_W-1:0]    rd_weight_q;
  logic                   rd_valid_q;
  logic                   rd_diag_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_weight;
    end
    rd_weight_q <= mem[req_i.rd_addr];
  end

  // Clearing only drops the valid bits: an invalid entry reads as zero on the
  // diagonal and as no arc elsewhere.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_diag_q  <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.rd_addr];
      rd_diag_q  <= (req_i.rd_addr[ADDR_W-1:NODE_W] == req_i.rd_addr[NODE_W-1:0]);
    end
  end

  assign rd_o.no_arc = !rd_valid_q && !rd_diag_q;
  assign rd_o.weight = rd_valid_q ? rd_weight_q : '0;

endmodule

`default_nettype wire

### rtl/apsp_path_mem.sv
// Distance and next-hop memory: one write port, two write-first read ports.
`default_nettype none

module apsp_path_mem (
  input  logic                  clk_i,
  input  apsp_pkg::path_req_t   req_i,
  output apsp_pkg::path_entry_t rd_a_o,
  output apsp_pkg::path_entry_t rd_b_o
);
  import apsp_pkg::*;

  path_entry_t mem [NUM_ENTRIES];
  path_entry_t rd_a_q;
  path_entry_t rd_b_q;

  // A read of the entry being written returns the new data, which covers the
  // read-modify-write overlap at row and pass boundaries.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.wr_en && (req_i.wr_addr == req_i.rd_a_addr)) begin
      rd_a_q <= req_i.wr_data;
    end else begin
      rd_a_q <= mem[req_i.rd_a_addr];
    end
    if (req_i.wr_en && (req_i.wr_addr == req_i.rd_b_addr)) begin
      rd_b_q <= req_i.wr_data;
    end else begin
      rd_b_q <= mem[req_i.rd_b_addr];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

### rtl/apsp_ctrl.sv
// Sequencer: matrix set-up, relaxation sweep, path walk and result emission.
`default_nettype none

module apsp_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [apsp_pkg::CNT_W-1:0]      n_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [apsp_pkg::FUNC_W-1:0]     func_i,
  input  apsp_pkg::node_t                 from_node_i,
  input  apsp_pkg::node_t                 to_node_i,
  input  logic [apsp_pkg::WEIGHT_W-1:0]   arc_weight_i,
  output apsp_pkg::arc_req_t              arc_req_o,
  input  apsp_pkg::arc_entry_t            arc_rd_i,
  output apsp_pkg::path_req_t             path_req_o,
  input  apsp_pkg::path_entry_t           path_rd_a_i,
  input  apsp_pkg::path_entry_t           path_rd_b_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output apsp_pkg::node_t                 path_node_o,
  output logic [apsp_pkg::DIST_W-1:0]     total_distance_o,
  output logic                            found_o,
  output logic                            last_o
);
  import apsp_pkg::*;

  function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  state_e state_q, state_d;

  node_t i_q, j_q, k_q;
  node_t cur_q, dst_q, nx_q;
  addr_t pend_addr_q;
  logic  init_pend_q, rlx_pend_q, row_first_q;
  logic  first_q, nf_q;
  logic [CNT_W-1:0]     hops_q, count_q;
  logic [RES_IDX_W-1:0] emit_q;
  logic [DIST_W-1:0]    total_q;
  dist_t dik_q;
  hop_t  hik_q;
  node_t path_buf_q [MAX_RESULTS];

  logic              out_valid_q;
  node_t             out_node_q;
  logic [DIST_W-1:0] out_total_q;
  logic              out_found_q;
  logic              out_last_q;

  node_t             n_last;
  logic              i_last, j_last, k_last;
  logic              query_acc, in_range;
  hop_t              hop_rd;
  logic              nf_hit, walk_stop;
  dist_t             dkj;
  logic [DIST_W:0]   dij;
  logic [DIST_W-1:0] relax_sum;
  logic              improve;
  logic              emit_load, emit_last;

  assign n_last    = NODE_W'(n_i - 1'b1);
  assign i_last    = (i_q == n_last);
  assign j_last    = (j_q == n_last);
  assign k_last    = (k_q == n_last);
  assign in_range  = ({1'b0, from_node_i} < n_i) && ({1'b0, to_node_i} < n_i);
  assign query_acc = (state_q == ST_IDLE) && in_valid_i && (func_i == FUNC_QUERY);

  // Walk: the next hop towards the target comes straight off read port A.
  assign hop_rd    = path_rd_a_i.hop;
  assign nf_hit    = first_q && hop_rd.none;
  assign walk_stop = nf_hit || (cur_q == dst_q) || (hops_q == n_i) || hop_rd.none ||
                     ({1'b0, hop_rd.node} >= n_i);

  // Relaxation of the entry read in the previous cycle.
  assign dkj       = path_rd_b_i.cost;
  assign dij       = path_rd_a_i.cost;
  assign relax_sum = sat_add(dik_q.val, dkj.val);
  assign improve   = rlx_pend_q && !dik_q.inf && !dkj.inf && (dij > {1'b0, relax_sum});

  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign emit_last = nf_q || (emit_q == RES_IDX_W'(count_q - 1'b1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          state_d = in_range ? ST_INIT : ST_EMIT;
        end
      end
      ST_INIT: begin
        if (i_last && j_last) begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        if (j_last) begin
          state_d = (i_last && k_last) ? ST_WALK_START : ST_ROW;
        end
      end
      ST_WALK_START: begin
        state_d = ST_WALK_HOP;
      end
      ST_WALK_HOP: begin
        state_d = walk_stop ? ST_EMIT : ST_WALK_DIST;
      end
      ST_WALK_DIST: begin
        state_d = ST_WALK_HOP;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);

    arc_req_o.clr       = (state_q == ST_IDLE) && in_valid_i && (func_i == FUNC_CLEAR);
    arc_req_o.wr_en     = (state_q == ST_IDLE) && in_valid_i && (func_i == FUNC_LOAD);
    arc_req_o.wr_addr   = {from_node_i, to_node_i};
    arc_req_o.wr_weight = arc_weight_i;
    arc_req_o.rd_addr   = {i_q, j_q};

    path_req_o.wr_en   = 1'b0;
    path_req_o.wr_addr = pend_addr_q;
    path_req_o.wr_data = '{cost: '{inf: 1'b0, val: relax_sum}, hop: hik_q};
    if (init_pend_q) begin
      path_req_o.wr_en = 1'b1;
      if (arc_rd_i.no_arc) begin
        path_req_o.wr_data = '{cost: '{inf: 1'b1, val: '0}, hop: '{none: 1'b1, node: '0}};
      end else begin
        path_req_o.wr_data = '{cost: '{inf: 1'b0, val: DIST_W'(arc_rd_i.weight)},
                               hop:  '{none: 1'b0, node: pend_addr_q[NODE_W-1:0]}};
      end
    end else if (improve) begin
      path_req_o.wr_en = 1'b1;
    end

    path_req_o.rd_b_addr = {k_q, j_q};
    case (state_q)
      ST_ROW:        path_req_o.rd_a_addr = {i_q, k_q};
      ST_RELAX:      path_req_o.rd_a_addr = {i_q, j_q};
      ST_WALK_HOP:   path_req_o.rd_a_addr = {cur_q, hop_rd.node};
      ST_WALK_DIST:  path_req_o.rd_a_addr = {nx_q, dst_q};
      default:       path_req_o.rd_a_addr = {cur_q, dst_q};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      init_pend_q <= 1'b0;
      rlx_pend_q  <= 1'b0;
      row_first_q <= 1'b0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      first_q     <= 1'b0;
      nf_q        <= 1'b0;
      count_q     <= '0;
      hops_q      <= '0;
      emit_q      <= '0;
    end else begin
      state_q     <= state_d;
      init_pend_q <= (state_q == ST_INIT);
      rlx_pend_q  <= (state_q == ST_RELAX);
      row_first_q <= (state_q == ST_ROW);
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (query_acc) begin
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            nf_q    <= !in_range;
            first_q <= 1'b1;
            count_q <= CNT_W'(1);
            hops_q  <= '0;
            emit_q  <= '0;
          end
        end
        ST_INIT: begin
          if (j_last) begin
            j_q <= '0;
            i_q <= i_last ? '0 : i_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_RELAX: begin
          if (j_last) begin
            j_q <= '0;
            if (i_last) begin
              i_q <= '0;
              k_q <= k_q + 1'b1;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_WALK_HOP: begin
          first_q <= 1'b0;
          if (nf_hit) begin
            nf_q <= 1'b1;
          end
        end
        ST_WALK_DIST: begin
          if (count_q < CNT_W'(MAX_RESULTS)) begin
            count_q <= count_q + 1'b1;
          end
          hops_q <= hops_q + 1'b1;
        end
        ST_EMIT: begin
          if (emit_load && !emit_last) begin
            emit_q <= emit_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q <= {i_q, j_q};
    case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          cur_q         <= from_node_i;
          dst_q         <= to_node_i;
          total_q       <= '0;
          path_buf_q[0] <= from_node_i;
        end
      end
      ST_RELAX: begin
        // Row and column k do not change during pass k, so d[i][k] is held for the row.
        if (row_first_q) begin
          dik_q <= path_rd_a_i.cost;
          hik_q <= path_rd_a_i.hop;
        end
      end
      ST_WALK_HOP: begin
        nx_q <= hop_rd.node;
      end
      ST_WALK_DIST: begin
        if (!path_rd_a_i.cost.inf) begin
          total_q <= sat_add(total_q, path_rd_a_i.cost.val);
        end
        if (count_q < CNT_W'(MAX_RESULTS)) begin
          path_buf_q[count_q[RES_IDX_W-1:0]] <= nx_q;
        end
        cur_q <= nx_q;
      end
      ST_EMIT: begin
        if (emit_load) begin
          out_node_q  <= nf_q ? '0 : path_buf_q[emit_q];
          out_total_q <= nf_q ? '0 : total_q;
          out_found_q <= !nf_q;
          out_last_q  <= emit_last;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign path_node_o      = out_node_q;
  assign total_distance_o = out_total_q;
  assign found_o          = out_found_q;
  assign last_o           = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RESULTS))
    else $error("path buffer count beyond its depth");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !nf_q |-> ({1'b0, emit_q} < count_q))
    else $error("emission index past the stored path");

  a_not_found_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_found_q |-> out_last_q)
    else $error("not-found result without last flag");

  a_hops_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK_HOP) || (state_q == ST_WALK_DIST) |-> (hops_q <= n_i))
    else $error("path walk exceeded the node count");
`endif

endmodule

`default_nettype wire

### rtl/all_pairs_shortest_path_engine.sv
// Top level of the all-pairs shortest path engine.
//
// Input channel (in_valid_i/in_ready_o) takes one command per transaction:
// clear all arcs, load one directed arc, or query the shortest path between
// two nodes. Clear and load give no result. A query builds the distance and
// next-hop matrices from the arc matrix, runs the relaxation sweep (one
// relaxation per cycle within a row, on the memory's two read ports), walks
// the path hop by hop and then emits one result per path node, source first,
// each carrying the total distance, the last one flagged. A missing path
// gives one not-found result.
// New commands are accepted once the final result is in the output register,
// so the next command can enter while that result still waits.
// Results wait in the output register while out_ready_i is low; the walk
// buffer holds the rest. The node count register (cfg channel, always ready)
// is 16 after reset; reset also leaves the arc matrix empty with a zero
// diagonal, with no clearing pass.
`default_nettype none

module all_pairs_shortest_path_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [apsp_pkg::FUNC_W-1:0]     func_i,
  input  logic [apsp_pkg::NODE_W-1:0]     from_node_i,
  input  logic [apsp_pkg::NODE_W-1:0]     to_node_i,
  input  logic [apsp_pkg::WEIGHT_W-1:0]   arc_weight_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [apsp_pkg::NODE_W-1:0]     path_node_o,
  output logic [apsp_pkg::DIST_W-1:0]     total_distance_o,
  output logic                            found_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apsp_pkg::CNT_W-1:0]      cfg_data_i
);
  import apsp_pkg::*;

  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] n_active;
  arc_req_t         arc_req;
  arc_entry_t       arc_rd;
  path_req_t        path_req;
  path_entry_t      path_rd_a;
  path_entry_t      path_rd_b;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // A count of zero acts as one node, anything above the matrix size as full size.
  always_comb begin
    if (node_count_q == '0) begin
      n_active = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n_active = CNT_W'(MAX_NODES);
    end else begin
      n_active = node_count_q;
    end
  end

  apsp_arc_mem u_arc_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arc_req),
    .rd_o   (arc_rd)
  );

  apsp_path_mem u_path_mem (
    .clk_i  (clk_i),
    .req_i  (path_req),
    .rd_a_o (path_rd_a),
    .rd_b_o (path_rd_b)
  );

  apsp_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .n_i              (n_active),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .from_node_i      (from_node_i),
    .to_node_i        (to_node_i),
    .arc_weight_i     (arc_weight_i),
    .arc_req_o        (arc_req),
    .arc_rd_i         (arc_rd),
    .path_req_o       (path_req),
    .path_rd_a_i      (path_rd_a),
    .path_rd_b_i      (path_rd_b),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .path_node_o      (path_node_o),
    .total_distance_o (total_distance_o),
    .found_o          (found_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
